### hdl/sdf_pkg.sv
`timescale 1ns / 1ps

package sdf_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // Width of the pattern length register.
    localparam int LEN_W = 5;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 2'd2;

    typedef logic [7:0] byte_t;

    // One result word as it travels through the output queue.
    typedef struct packed {
        byte_t char_out;
        logic  no_byte;
        logic  last_out;
    } result_word_t;

endpackage

### hdl/substring_deletion_filter.sv
`timescale 1ns / 1ps

// Channel   Direction  Ports                                          Word
// -------   ---------  ---------------------------------------------  ----------------------
// s_        in         s_valid s_ready s_char_in s_end_of_string      one string byte
// m_        out        m_valid m_ready m_char_out m_no_byte m_last_out one kept byte or end mark
// cfg_      in         cfg_wr_en cfg_index cfg_wdata                  register write, no wait
//
// One input word is taken per cycle while the output queue has room and no earlier word
// still owes results. Results pass through the registered output queue to m_ in order.
// A word that produces more than one result (end of string flush, or a shortened pattern
// length) holds s_ready low until its extra results, up to PATTERN_MAX - 1 of them, have
// drained, as the window pushes one byte per cycle into the output queue while it has room.
// A two-word output queue lets s_ accept while a result waits for m_ready.
// aresetn is synchronous and active low; it empties the window and the queue and returns
// the pattern length to one with an all-zero pattern.

module substring_deletion_filter import sdf_pkg::*; #(
    parameter int PATTERN_MAX = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_char_in,
    input  logic                  s_end_of_string,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_char_out,
    output logic                  m_no_byte,
    output logic                  m_last_out
);

    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int CNT_W = $clog2(PATTERN_MAX + 1);

    // Configuration registers.
    logic [LEN_W-1:0]      pat_len_reg;
    logic [CFG_DATA_W-1:0] pat_low_reg;
    logic [CFG_DATA_W-1:0] pat_high_reg;

    // Pending window, oldest byte at index zero. The first win_cnt_reg entries are live.
    // drain_reg counts bytes at the head still owed to the output after a multi-result word.
    byte_t [PATTERN_MAX-1:0] win_reg;
    byte_t [PATTERN_MAX-1:0] win_next;
    logic  [CNT_W-1:0]       win_cnt_reg;
    logic  [CNT_W-1:0]       win_cnt_next;
    logic  [CNT_W-1:0]       drain_reg;
    logic  [CNT_W-1:0]       drain_next;
    logic                    drain_last_reg;
    logic                    drain_last_next;

    byte_t [PATTERN_MAX-1:0] app;
    byte_t [PATTERN_MAX-1:0] app_shift;
    byte_t [PATTERN_MAX-1:0] win_shift;
    logic  [CNT_W-1:0]       len_eff;
    logic  [CNT_W-1:0]       fill;
    logic  [CNT_W-1:0]       tail_start;
    logic  [CNT_W-1:0]       new_cnt;
    logic  [CNT_W-1:0]       emit_cnt;
    logic                    full;
    logic                    match;
    logic                    accept;
    logic                    push;
    result_word_t            push_word;
    result_word_t            out_word;
    logic                    q_not_full;

    // A length of zero acts as one and anything beyond the window size is clamped.
    always_comb begin
        if (pat_len_reg == '0) begin
            len_eff = CNT_W'(1);
        end else if (pat_len_reg > LEN_W'(PATTERN_MAX)) begin
            len_eff = CNT_W'(PATTERN_MAX);
        end else begin
            len_eff = pat_len_reg[CNT_W-1:0];
        end
    end

    // Append the incoming byte behind the live entries. The window never holds more than
    // PATTERN_MAX - 1 bytes between words, so the new byte always has a slot.
    always_comb begin
        app = win_reg;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if (IDX_W'(i) == win_cnt_reg[IDX_W-1:0]) begin
                app[i] = s_char_in;
            end
        end
        fill = win_cnt_reg + CNT_W'(1);
    end

    // Both shifted views drop the oldest byte.
    always_comb begin
        app_shift = '0;
        win_shift = '0;
        for (int i = 0; i < PATTERN_MAX - 1; i++) begin
            app_shift[i] = app[i+1];
            win_shift[i] = win_reg[i+1];
        end
    end

    sdf_match #(
        .PATTERN_MAX (PATTERN_MAX),
        .CNT_W       (CNT_W)
    ) u_match (
        .window     (app),
        .fill       (fill),
        .pat_len    (len_eff),
        .pattern    ({pat_high_reg, pat_low_reg}),
        .full       (full),
        .match      (match),
        .tail_start (tail_start)
    );

    // The bytes that leave for the output are always a prefix of the appended window.
    // Everything in front of a match goes out and the matched tail is dropped by the count.
    // Without a match and a full window, one more byte goes. At the end of a string all
    // remaining bytes go.
    always_comb begin
        new_cnt = match ? tail_start : fill;
        if (s_end_of_string) begin
            emit_cnt = new_cnt;
        end else if (match) begin
            emit_cnt = tail_start;
        end else if (full) begin
            emit_cnt = tail_start + CNT_W'(1);
        end else begin
            emit_cnt = '0;
        end
    end

    assign s_ready = (drain_reg == '0) && q_not_full;
    assign accept  = s_valid && s_ready;

    // The first result of a word is pushed in the same cycle it is accepted; further results
    // drain from the window head one per cycle while s_ready is low and the queue has room.
    always_comb begin
        win_next        = win_reg;
        win_cnt_next    = win_cnt_reg;
        drain_next      = drain_reg;
        drain_last_next = drain_last_reg;
        push            = 1'b0;
        push_word       = '0;
        if (accept) begin
            drain_last_next = s_end_of_string;
            if (emit_cnt != '0) begin
                push               = 1'b1;
                push_word.char_out = app[0];
                push_word.last_out = s_end_of_string && (emit_cnt == CNT_W'(1));
                win_next           = app_shift;
                win_cnt_next       = new_cnt - CNT_W'(1);
                drain_next         = emit_cnt - CNT_W'(1);
            end else begin
                win_next     = app;
                win_cnt_next = new_cnt;
                drain_next   = '0;
                if (s_end_of_string) begin
                    // Nothing was left of the string, so only the end is marked.
                    push              = 1'b1;
                    push_word.no_byte = 1'b1;
                    push_word.last_out = 1'b1;
                end
            end
        end else if ((drain_reg != '0) && q_not_full) begin
            push               = 1'b1;
            push_word.char_out = win_reg[0];
            push_word.last_out = drain_last_reg && (drain_reg == CNT_W'(1));
            win_next           = win_shift;
            win_cnt_next       = win_cnt_reg - CNT_W'(1);
            drain_next         = drain_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_len_reg    <= LEN_W'(1);
            pat_low_reg    <= '0;
            pat_high_reg   <= '0;
            win_cnt_reg    <= '0;
            drain_reg      <= '0;
            drain_last_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_PATTERN_LENGTH: begin
                        pat_len_reg <= cfg_wdata[LEN_W-1:0];
                    end
                    CFG_PATTERN_LOW: begin
                        pat_low_reg <= cfg_wdata;
                    end
                    CFG_PATTERN_HIGH: begin
                        pat_high_reg <= cfg_wdata;
                    end
                    default: begin
                    end
                endcase
            end
            win_cnt_reg    <= win_cnt_next;
            drain_reg      <= drain_next;
            drain_last_reg <= drain_last_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

    sdf_out_queue u_out_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_word (push_word),
        .pop_ready (m_ready),
        .out_valid (m_valid),
        .out_word  (out_word),
        .not_full  (q_not_full)
    );

    assign m_char_out = out_word.char_out;
    assign m_no_byte  = out_word.no_byte;
    assign m_last_out = out_word.last_out;

    // Bytes owed to the output must still be in the window.
    assert property (@(posedge aclk) disable iff (!aresetn) drain_reg <= win_cnt_reg)
        else $error("drain count exceeds window fill");

    // Between words there must be room for the next byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        win_cnt_reg < CNT_W'(PATTERN_MAX))
        else $error("window left full between words");

    // After the end of a string every remaining byte is owed to the output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        drain_last_reg |-> (win_cnt_reg == drain_reg))
        else $error("bytes left in the window after the end of a string");

endmodule

### hdl/sdf_match.sv
`timescale 1ns / 1ps

module sdf_match import sdf_pkg::*; #(
    parameter int PATTERN_MAX = 16,
    parameter int CNT_W       = 5
) (
    input  byte_t [PATTERN_MAX-1:0]     window,
    input  logic  [CNT_W-1:0]           fill,
    input  logic  [CNT_W-1:0]           pat_len,
    input  logic  [2*CFG_DATA_W-1:0]    pattern,
    output logic                        full,
    output logic                        match,
    output logic  [CNT_W-1:0]           tail_start
);

    logic [PATTERN_MAX*8-1:0] tail;
    logic [PATTERN_MAX-1:0]   byte_ok;

    // The newest pat_len bytes are brought down to position zero by a barrel
    // shift, then compared byte for byte against the pattern.
    always_comb begin
        full       = (fill >= pat_len);
        tail_start = fill - pat_len;
        tail       = window >> {tail_start, 3'b000};
        for (int i = 0; i < PATTERN_MAX; i++) begin
            byte_ok[i] = (CNT_W'(i) >= pat_len) || (tail[i*8 +: 8] == pattern[i*8 +: 8]);
        end
        match = full && (&byte_ok);
    end

endmodule

### hdl/sdf_out_queue.sv
`timescale 1ns / 1ps

module sdf_out_queue import sdf_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  result_word_t push_word,
    input  logic         pop_ready,
    output logic         out_valid,
    output result_word_t out_word,
    output logic         not_full
);

    localparam logic [1:0] DEPTH = 2'd2;

    result_word_t slot_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;
    logic         wr_ptr_next;
    logic         rd_ptr_next;
    logic [1:0]   count_next;
    logic         pop;

    assign out_valid = (count_reg != 2'd0);
    assign out_word  = slot_reg[rd_ptr_reg];
    assign not_full  = (count_reg != DEPTH);
    assign pop       = out_valid && pop_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) count_reg <= DEPTH)
        else $error("output queue count beyond its depth");

    assert property (@(posedge aclk) disable iff (!aresetn) push |-> (count_reg != DEPTH))
        else $error("word pushed into a full output queue");

    // A word offered on the output stays in place until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !pop_ready) |=> (out_valid && $stable(out_word)))
        else $error("output word changed while waiting");

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the substring deletion filter.
module testbench;
    import sdf_pkg::*;

    localparam int PATTERN_MAX = 16;

    // The configuration port has room for a fourth index that maps to no register.
    // Writes to it must leave the block alone.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    // The cycle limit ends a run that hangs.
    // It leaves a wide margin on top of the slowest correct run.
    localparam int unsigned CYCLE_LIMIT = 400000;

    // Words to send in each configuration of the random part.
    localparam int unsigned WORDS_PER_SETTING = 12;

    // Scoreboard. It tracks the pending window and the registers of the filter.
    // From every accepted input word it predicts the kept bytes in order.
    class deletion_scoreboard;
        logic [LEN_W-1:0] len_reg;
        logic [63:0]      pattern_lo;
        logic [63:0]      pattern_hi;
        byte_t            window [PATTERN_MAX];
        int unsigned      held;
        result_word_t     kept_q [$];
        int unsigned      errors;

        function new();
            len_reg    = 1;
            pattern_lo = '0;
            pattern_hi = '0;
            errors     = 0;
            clear_window();
        endfunction

        function void clear_window();
            foreach (window[i]) window[i] = 8'h00;
            held = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_PATTERN_LENGTH: len_reg = data[LEN_W-1:0];
                CFG_PATTERN_LOW:    pattern_lo = data;
                CFG_PATTERN_HIGH:   pattern_hi = data;
                default: ;
            endcase
        endfunction

        // A length of zero behaves as one. A length above the window size is clipped to it.
        function int unsigned eff_len();
            if (len_reg == 0) return 1;
            if (len_reg > PATTERN_MAX) return PATTERN_MAX;
            return len_reg;
        endfunction

        function byte_t pattern_byte(int unsigned k);
            if (k < 8) return pattern_lo[8*k +: 8];
            return pattern_hi[8*(k-8) +: 8];
        endfunction

        function void emit_oldest();
            kept_q.push_back('{char_out: window[0], no_byte: 1'b0, last_out: 1'b0});
            for (int i = 1; i < held; i++) window[i-1] = window[i];
            held--;
            window[held] = 8'h00;
        endfunction

        function void note_word(byte_t ch, logic eos);
            int unsigned  len;
            int unsigned  start;
            bit           hit;
            result_word_t tail;
            len   = eff_len();
            start = kept_q.size();
            // The length may have been shortened while bytes were pending.
            while (held >= len) emit_oldest();
            window[held] = ch;
            held++;
            if (held == len) begin
                hit = 1'b1;
                for (int k = 0; k < len; k++)
                    if (window[k] != pattern_byte(k)) hit = 1'b0;
                if (hit) begin
                    clear_window();
                end else begin
                    emit_oldest();
                end
            end
            if (eos) begin
                while (held > 0) emit_oldest();
                if (kept_q.size() == start)
                    kept_q.push_back('{char_out: 8'h00, no_byte: 1'b1, last_out: 1'b0});
                tail = kept_q.pop_back();
                tail.last_out = 1'b1;
                kept_q.push_back(tail);
                clear_window();
            end
        endfunction

        function int unsigned pending();
            return kept_q.size();
        endfunction

        task report(string msg);
            $display("MISMATCH %s", msg);
            errors++;
        endtask

        task check_word(byte_t ch, logic nob, logic last);
            result_word_t want;
            if (kept_q.size() == 0) begin
                report($sformatf("result word with none expected: char 0x%02h no_byte %0b last %0b",
                                 ch, nob, last));
            end else begin
                want = kept_q.pop_front();
                if (ch !== want.char_out)
                    report($sformatf("char_out: expected 0x%02h, got 0x%02h", want.char_out, ch));
                if (nob !== want.no_byte)
                    report($sformatf("no_byte: expected %0b, got %0b", want.no_byte, nob));
                if (last !== want.last_out)
                    report($sformatf("last_out: expected %0b, got %0b", want.last_out, last));
            end
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [7:0]            s_char_in;
    logic                  s_end_of_string;
    logic                  m_valid;
    logic                  m_ready;
    logic [7:0]            m_char_out;
    logic                  m_no_byte;
    logic                  m_last_out;

    // Idle rates in percent. The stimulus process changes them from phase to phase.
    int unsigned src_idle_pct   = 6;
    int unsigned sink_stall_pct = 47;
    int unsigned cycle_count    = 0;

    deletion_scoreboard sb;

    substring_deletion_filter #(
        .PATTERN_MAX(PATTERN_MAX)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_char_in       (s_char_in),
        .s_end_of_string (s_end_of_string),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_char_out      (m_char_out),
        .m_no_byte       (m_no_byte),
        .m_last_out      (m_last_out)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // The receiver draws a fresh ready level at every falling edge.
    // A stall rate of zero keeps ready high all the time.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Both channels are sampled at the rising edge, where a handshake completes.
    // Results are checked before the input is noted.
    // A word accepted at this edge can only produce results at later edges.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_word(m_char_out, m_no_byte, m_last_out);
            if (s_valid && s_ready)
                sb.note_word(s_char_in, s_end_of_string);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offers one word on the input channel and returns at the falling edge after it is taken.
    // The caller must already be at a falling edge. Random gaps come before the word.
    // Valid is assigned once per edge, so it never drops while a word is on offer.
    task send_word(input byte_t ch, input logic eos);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_char_in       <= ch;
        s_end_of_string <= eos;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Performs a single register write.
    // The scoreboard takes the new value at the same edge as the block.
    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.write_reg(idx, data);
        @(negedge aclk);
    endtask

    // Writes every register, then the unused index with random data.
    // The upper bits of the length write are random. Only the low five bits should count.
    task configure(input logic [LEN_W-1:0] len_val, input logic [63:0] lo, input logic [63:0] hi);
        logic [CFG_DATA_W-1:0] len_data;
        len_data            = {$urandom, $urandom};
        len_data[LEN_W-1:0] = len_val;
        write_reg(CFG_PATTERN_LENGTH, len_data);
        write_reg(CFG_PATTERN_LOW, lo);
        write_reg(CFG_PATTERN_HIGH, hi);
        write_reg(CFG_UNUSED_INDEX, {$urandom, $urandom});
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Drops valid and waits until every expected word has come back.
    // A word that produces no result can still be inside the block at that point.
    // A further wait lets it settle before any register changes.
    task wait_idle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (PATTERN_MAX + 4) @(negedge aclk);
    endtask

    // Builds one string from pieces and sends it, with the end flag on the last byte.
    // Most pieces are whole pattern copies, partial prefixes or single pattern bytes.
    // Matches therefore happen often. The rest are random bytes.
    task send_string(input int unsigned pieces, output int unsigned count);
        byte_t       text [$];
        int unsigned len;
        int unsigned cut;
        int unsigned pick;
        len = sb.eff_len();
        repeat (pieces) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                for (int k = 0; k < len; k++) text.push_back(sb.pattern_byte(k));
            end else if (pick < 6) begin
                cut = $urandom_range(0, len - 1);
                for (int k = 0; k < cut; k++) text.push_back(sb.pattern_byte(k));
                text.push_back(byte_t'($urandom_range(0, 255)));
            end else if (pick < 8) begin
                text.push_back(sb.pattern_byte($urandom_range(0, len - 1)));
            end else begin
                text.push_back(byte_t'($urandom_range(0, 255)));
            end
        end
        foreach (text[i]) send_word(text[i], i == text.size() - 1);
        count = text.size();
    endtask

    initial begin
        logic [LEN_W-1:0] len_val;
        logic [63:0]      lo_word;
        int unsigned      sent;
        int unsigned      count;
        int unsigned      tail_len;

        sb              = new();
        aresetn         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = CFG_PATTERN_LENGTH;
        cfg_wdata       = '0;
        s_valid         = 1'b0;
        s_char_in       = 8'h00;
        s_end_of_string = 1'b0;
        m_ready         = 1'b0;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part. It starts from the reset registers: a one-byte pattern of zero.
        // Zero bytes are deleted and other bytes pass through.
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b1);
        // The whole string is deleted here. Only an end mark with no byte comes out.
        send_word(8'h00, 1'b1);
        wait_idle();

        // A length of zero must behave as a one-byte pattern.
        lo_word = {$urandom, $urandom};
        lo_word[7:0] = 8'hA5;
        configure(5'd0, lo_word, {$urandom, $urandom});
        send_word(8'hA5, 1'b0);
        send_word(8'h5A, 1'b0);
        send_word(8'hA5, 1'b1);
        wait_idle();

        // A length above the maximum is clipped to sixteen.
        // Fifteen bytes fill the window with no output.
        // Then the length drops to one in the middle of the string.
        // The next word must release all fifteen pending bytes.
        // That word is not a match and is the last of the string.
        // It gives the largest number of results from a single word.
        configure(5'd31, {$urandom, $urandom}, {$urandom, $urandom});
        repeat (15) send_word(byte_t'($urandom_range(0, 255)), 1'b0);
        wait_idle();
        lo_word = {$urandom, $urandom};
        configure(5'd1, lo_word, {$urandom, $urandom});
        send_word(~lo_word[7:0], 1'b1);
        wait_idle();

        // Random part in three phases.
        // The sender idles lightly while the receiver stalls heavily.
        // Then the two swap. In the last phase neither side idles.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct   = 6;
                    sink_stall_pct = 47;
                end
                1: begin
                    src_idle_pct   = 47;
                    sink_stall_pct = 6;
                end
                default: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
            endcase
            for (int setting = 0; setting < 3; setting++) begin
                wait_idle();
                case ($urandom_range(0, 9))
                    0:       len_val = 5'd0;
                    1:       len_val = 5'd16;
                    2:       len_val = LEN_W'($urandom_range(17, 31));
                    3:       len_val = 5'd1;
                    default: len_val = LEN_W'($urandom_range(2, 6));
                endcase
                configure(len_val, {$urandom, $urandom}, {$urandom, $urandom});
                sent = 0;
                while (sent < WORDS_PER_SETTING) begin
                    send_string($urandom_range(1, 5), count);
                    sent += count;
                end
                // Sometimes a string is left open here.
                // The next setting then changes the length while bytes are pending.
                if ($urandom_range(0, 1) == 1) begin
                    tail_len = $urandom_range(1, 3);
                    for (int k = 0; k < tail_len; k++)
                        send_word(sb.pattern_byte(k % sb.eff_len()), 1'b0);
                end
            end
        end

        // Close any open string, then let the block drain.
        send_word(byte_t'($urandom_range(0, 255)), 1'b1);
        wait_idle();
        repeat (2 * PATTERN_MAX) @(posedge aclk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### sim.f
hdl/sdf_pkg.sv
hdl/sdf_match.sv
hdl/sdf_out_queue.sv
hdl/substring_deletion_filter.sv
verif/testbench.sv
